@@ hw/rtl/xsid_pkg.sv @@
// ----------------------------------------------------------------------------
// xsid_pkg
// Shared types, opcode constants and decode tables of the x86 subset decoder.
// ----------------------------------------------------------------------------
package xsid_pkg;

    // status codes carried with each record
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_UNKNOWN = 2'd1;
    localparam logic [1:0] ST_UNSUP   = 2'd2;
    localparam logic [1:0] ST_TRUNC   = 2'd3;

    // special bytes
    localparam logic [7:0] OP_REP     = 8'hF3;
    localparam logic [7:0] OP_ESC     = 8'h0F;
    localparam logic [7:0] OP_ENDBR_2 = 8'h1E;
    localparam logic [7:0] OP_ENDBR_3 = 8'hFB;
    localparam logic [7:0] OP_GS      = 8'h65;
    localparam logic [7:0] OP_RET     = 8'hC3;
    localparam logic [7:0] OP_MOVZX   = 8'hB6;
    localparam logic [7:0] OP_TEST    = 8'h84;
    localparam logic [7:0] OP_XOR_RM  = 8'h31;
    localparam logic [7:0] OP_XOR_GS  = 8'h33;
    localparam logic [7:0] OP_GRP5    = 8'hFF;
    localparam logic [7:0] OP_GRP1_8  = 8'h83;
    localparam logic [7:0] OP_GRP1_32 = 8'h81;

    // remaining opcodes of the subset
    localparam logic [7:0] OP_NOP           = 8'h90;
    localparam logic [7:0] OP_PUSH_EBP      = 8'h55;
    localparam logic [7:0] OP_LEAVE         = 8'hC9;
    localparam logic [7:0] OP_PUSH_EBX      = 8'h53;
    localparam logic [7:0] OP_PUSH_EDX      = 8'h52;
    localparam logic [7:0] OP_PUSH_EAX      = 8'h50;
    localparam logic [7:0] OP_MOV_RM_R      = 8'h89;
    localparam logic [7:0] OP_MOV_R_RM      = 8'h8B;
    localparam logic [7:0] OP_LEA           = 8'h8D;
    localparam logic [7:0] OP_ADD_RM_R      = 8'h01;
    localparam logic [7:0] OP_CMP_R_RM      = 8'h3B;
    localparam logic [7:0] OP_CMP_RM_R      = 8'h39;
    localparam logic [7:0] OP_MOV_RM_IMM    = 8'hC7;
    localparam logic [7:0] OP_CALL          = 8'hE8;
    localparam logic [7:0] OP_ADD_EAX_IMM   = 8'h05;
    localparam logic [7:0] OP_MOV_EAX_IMM   = 8'hB8;
    localparam logic [7:0] OP_MOV_EAX_MOFFS = 8'hA1;
    localparam logic [7:0] OP_JMP_SHORT     = 8'hEB;
    localparam logic [7:0] OP_JLE           = 8'h7E;
    localparam logic [7:0] OP_JNE           = 8'h75;
    localparam logic [7:0] OP_JB            = 8'h72;
    localparam logic [7:0] OP_JA            = 8'h77;
    localparam logic [7:0] OP_JE            = 8'h74;
    localparam logic [7:0] OP_CMP_AL_IMM    = 8'h3C;
    localparam logic [7:0] OP_PUSH_IMM8     = 8'h6A;

    typedef struct packed {
        logic [7:0] code_byte;
        logic       end_of_buffer;
    } t_in_item;

    typedef struct packed {
        logic [7:0]  opcode;
        logic        extended;
        logic [1:0]  status;
        logic [1:0]  mode_bits;
        logic [2:0]  reg_bits;
        logic [2:0]  rm_bits;
        logic [31:0] displacement;
        logic [31:0] immediate;
        logic [31:0] branch_target;
        logic [31:0] start_address;
        logic [3:0]  length;
        logic        function_end;
    } t_record;

    typedef struct packed {
        logic known;
        logic modrm;
        logic imm8;
        logic imm32;
        logic branch;
        logic gs;
    } t_op_class;

    function automatic t_op_class op_class(input logic [7:0] op, input logic ext);
        t_op_class c;
        c = '0;
        if (ext) begin
            if (op == OP_MOVZX || op == OP_TEST) begin
                c.known = 1'b1;
                c.modrm = 1'b1;
            end
        end else begin
            unique case (op)
                OP_NOP, OP_PUSH_EBP, OP_LEAVE, OP_RET, OP_PUSH_EBX, OP_PUSH_EDX,
                OP_PUSH_EAX: begin
                    c.known = 1'b1;
                end
                OP_MOV_RM_R, OP_MOV_R_RM, OP_LEA, OP_ADD_RM_R, OP_TEST, OP_CMP_R_RM,
                OP_CMP_RM_R, OP_XOR_RM, OP_GRP5: begin
                    c.known = 1'b1;
                    c.modrm = 1'b1;
                end
                OP_XOR_GS: begin
                    c.known = 1'b1;
                    c.modrm = 1'b1;
                    c.gs    = 1'b1;
                end
                OP_GRP1_8: begin
                    c.known = 1'b1;
                    c.modrm = 1'b1;
                    c.imm8  = 1'b1;
                end
                OP_MOV_RM_IMM, OP_GRP1_32: begin
                    c.known = 1'b1;
                    c.modrm = 1'b1;
                    c.imm32 = 1'b1;
                end
                OP_CALL: begin
                    c.known  = 1'b1;
                    c.imm32  = 1'b1;
                    c.branch = 1'b1;
                end
                OP_ADD_EAX_IMM, OP_MOV_EAX_IMM: begin
                    c.known = 1'b1;
                    c.imm32 = 1'b1;
                end
                OP_MOV_EAX_MOFFS: begin
                    c.known = 1'b1;
                    c.imm32 = 1'b1;
                    c.gs    = 1'b1;
                end
                OP_JMP_SHORT, OP_JLE, OP_JNE, OP_JB, OP_JA, OP_JE: begin
                    c.known  = 1'b1;
                    c.imm8   = 1'b1;
                    c.branch = 1'b1;
                end
                OP_CMP_AL_IMM, OP_PUSH_IMM8: begin
                    c.known = 1'b1;
                    c.imm8  = 1'b1;
                end
                default: c = '0;
            endcase
        end
        return c;
    endfunction

    // ModR/M form check; SIB forms are never accepted
    function automatic logic form_ok(input logic [7:0] op, input logic ext,
                                     input logic [7:0] m);
        logic ok;
        ok = 1'b1;
        if (m[7:6] != 2'd3 && m[2:0] == 3'd4) begin
            ok = 1'b0;
        end else if (!ext) begin
            unique case (op)
                OP_XOR_RM:  ok = (m[7:6] == 2'd3);
                OP_XOR_GS:  ok = (m[7:6] == 2'd0) && (m[2:0] == 3'd5);
                OP_GRP5:    ok = (m[5:3] == 3'd6);
                OP_GRP1_8:  ok = (m[5:3] == 3'd0) || (m[5:3] == 3'd5) || (m[5:3] == 3'd7);
                OP_GRP1_32: ok = (m[5:3] == 3'd0);
                default:    ok = 1'b1;
            endcase
        end
        return ok;
    endfunction

    // displacement bytes following a ModR/M byte
    function automatic logic [2:0] disp_size(input logic [7:0] m);
        logic [2:0] s;
        unique case (m[7:6])
            2'd1:    s = 3'd1;
            2'd2:    s = 3'd4;
            2'd0:    s = (m[2:0] == 3'd5) ? 3'd4 : 3'd0;
            default: s = 3'd0;
        endcase
        return s;
    endfunction

    function automatic logic [2:0] imm_size(input t_op_class c);
        logic [2:0] s;
        if (c.imm32) begin
            s = 3'd4;
        end else if (c.imm8) begin
            s = 3'd1;
        end else begin
            s = 3'd0;
        end
        return s;
    endfunction

endpackage

@@ hw/rtl/xsid_in_reg.sv @@
// ----------------------------------------------------------------------------
// xsid_in_reg
// Input register for code bytes; holds one byte until the decode stage takes it.
// ----------------------------------------------------------------------------
module xsid_in_reg
    import xsid_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_s_tvalid,
    input  t_in_item i_item,
    output logic     o_s_tready,
    input  logic     i_take,
    output logic     o_valid,
    output t_in_item o_item
);

    logic     r_valid;
    t_in_item r_item;

    // empty, or the held byte moves on this cycle
    assign o_s_tready = !r_valid || i_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

@@ hw/rtl/xsid_core.sv @@
// ----------------------------------------------------------------------------
// xsid_core
// Decode state and per-byte decode logic; emits one record per instruction.
// ----------------------------------------------------------------------------
module xsid_core
    import xsid_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_wdata,
    input  logic        i_fire,
    input  t_in_item    i_item,
    output logic        o_rec_valid,
    output t_record     o_rec
);

    typedef enum logic [2:0] {
        PH_OP,
        PH_ESC,
        PH_ENDBR,
        PH_MODRM,
        PH_DISP,
        PH_IMM
    } t_phase;

    t_phase      r_phase,      n_phase;
    logic [7:0]  r_opcode,     n_opcode;
    logic        r_esc,        n_esc;
    logic [7:0]  r_modrm,      n_modrm;
    logic [2:0]  r_left,       n_left;
    logic [31:0] r_disp,       n_disp;
    logic [31:0] r_imm,        n_imm;
    logic        r_gs,         n_gs;
    logic [31:0] r_byte_addr,  n_byte_addr;
    logic [31:0] r_next_addr,  n_next_addr;
    logic [31:0] r_start,      n_start;
    logic [3:0]  r_len,        n_len;
    logic [31:0] r_base;
    logic [31:0] r_base_next;

    logic [7:0]  b;
    logic        rec_v;
    logic [1:0]  verdict;
    logic        do_begin;
    logic        do_after;
    t_op_class   cls_sel;
    t_op_class   cls_held;
    logic [2:0]  dsz;
    logic [2:0]  isz;
    logic [1:0]  idx;
    logic [3:0]  len_cur;
    logic [7:0]  endbr_exp;
    logic        ok;
    logic        br;
    t_record     rec;

    assign b        = i_item.code_byte;
    assign cls_held = op_class(r_opcode, r_esc);

    always_comb begin
        n_phase     = r_phase;
        n_opcode    = r_opcode;
        n_esc       = r_esc;
        n_modrm     = r_modrm;
        n_left      = r_left;
        n_disp      = r_disp;
        n_imm       = r_imm;
        n_gs        = r_gs;
        n_start     = r_start;
        n_byte_addr = r_byte_addr + 32'd1;
        n_next_addr = r_next_addr + 32'd1;
        rec_v       = 1'b0;
        verdict     = ST_OK;
        do_begin    = 1'b0;
        do_after    = 1'b0;
        cls_sel     = cls_held;
        dsz         = disp_size(r_modrm);
        isz         = imm_size(cls_held);
        idx         = 2'd0;
        endbr_exp   = OP_ENDBR_3;

        // first byte of a new instruction
        if (r_phase == PH_OP && !r_gs) begin
            n_start = r_byte_addr;
            len_cur = 4'd0;
        end else begin
            len_cur = r_len;
        end
        n_len = (len_cur == 4'd15) ? len_cur : len_cur + 4'd1;

        unique case (r_phase)
            PH_ESC: begin
                n_opcode = b;
                n_esc    = 1'b1;
                cls_sel  = op_class(b, 1'b1);
                do_begin = 1'b1;
            end
            PH_ENDBR: begin
                if (r_left == 3'd3) begin
                    endbr_exp = OP_ESC;
                end else if (r_left == 3'd2) begin
                    endbr_exp = OP_ENDBR_2;
                end
                if (b != endbr_exp) begin
                    rec_v   = 1'b1;
                    verdict = ST_UNSUP;
                end else begin
                    n_left = r_left - 3'd1;
                    if (r_left == 3'd1) begin
                        rec_v = 1'b1;
                    end
                end
            end
            PH_MODRM: begin
                n_modrm = b;
                dsz     = disp_size(b);
                if (!form_ok(r_opcode, r_esc, b)) begin
                    rec_v   = 1'b1;
                    verdict = ST_UNSUP;
                end else if (dsz != 3'd0) begin
                    n_phase = PH_DISP;
                    n_left  = dsz;
                end else begin
                    do_after = 1'b1;
                end
            end
            PH_DISP: begin
                idx = 2'(dsz - r_left);
                case (idx)
                    2'd0:    n_disp[7:0]   = b;
                    2'd1:    n_disp[15:8]  = b;
                    2'd2:    n_disp[23:16] = b;
                    default: n_disp[31:24] = b;
                endcase
                n_left = r_left - 3'd1;
                if (r_left == 3'd1) begin
                    if (dsz == 3'd1) begin
                        n_disp = {{24{b[7]}}, b};
                    end
                    do_after = 1'b1;
                end
            end
            PH_IMM: begin
                idx = 2'(isz - r_left);
                case (idx)
                    2'd0:    n_imm[7:0]   = b;
                    2'd1:    n_imm[15:8]  = b;
                    2'd2:    n_imm[23:16] = b;
                    default: n_imm[31:24] = b;
                endcase
                n_left = r_left - 3'd1;
                if (r_left == 3'd1) begin
                    if (isz == 3'd1) begin
                        n_imm = {{24{b[7]}}, b};
                    end
                    rec_v = 1'b1;
                end
            end
            default: begin
                if (b == OP_GS) begin
                    // a second prefix is an unsupported form
                    if (r_gs) begin
                        rec_v   = 1'b1;
                        verdict = ST_UNSUP;
                    end
                    n_opcode = OP_GS;
                    n_gs     = 1'b1;
                end else begin
                    n_opcode = b;
                    if (b == OP_ESC) begin
                        n_phase = PH_ESC;
                    end else if (b == OP_REP) begin
                        n_phase = PH_ENDBR;
                        n_left  = 3'd3;
                    end else begin
                        cls_sel  = op_class(b, 1'b0);
                        do_begin = 1'b1;
                    end
                end
            end
        endcase

        if (do_begin) begin
            if (!cls_sel.known) begin
                rec_v   = 1'b1;
                verdict = ST_UNKNOWN;
            end else if (cls_sel.gs && !r_gs) begin
                rec_v   = 1'b1;
                verdict = ST_UNSUP;
            end else if (cls_sel.modrm) begin
                n_phase = PH_MODRM;
            end else begin
                do_after = 1'b1;
            end
        end

        if (do_after) begin
            isz = imm_size(cls_sel);
            if (isz != 3'd0) begin
                n_phase = PH_IMM;
                n_left  = isz;
            end else begin
                rec_v = 1'b1;
            end
        end

        if (!rec_v && i_item.end_of_buffer) begin
            rec_v   = 1'b1;
            verdict = ST_TRUNC;
        end

        ok = rec_v && (verdict == ST_OK);
        // relative branches always complete in the immediate phase
        br = ok && (r_phase == PH_IMM) && cls_held.branch;

        rec.opcode        = n_opcode;
        rec.extended      = n_esc;
        rec.status        = verdict;
        rec.mode_bits     = n_modrm[7:6];
        rec.reg_bits      = n_modrm[5:3];
        rec.rm_bits       = n_modrm[2:0];
        rec.displacement  = ok ? n_disp : 32'd0;
        rec.immediate     = ok ? n_imm : 32'd0;
        rec.branch_target = br ? (r_next_addr + n_imm) : 32'd0;
        rec.start_address = n_start;
        rec.length        = n_len;
        rec.function_end  = ok && (n_opcode == OP_RET) && !n_esc;

        if (rec_v) begin
            n_phase  = PH_OP;
            n_opcode = 8'd0;
            n_esc    = 1'b0;
            n_modrm  = 8'd0;
            n_left   = 3'd0;
            n_disp   = 32'd0;
            n_imm    = 32'd0;
            n_gs     = 1'b0;
            n_len    = 4'd0;
            if (i_item.end_of_buffer) begin
                n_byte_addr = r_base;
                n_next_addr = r_base_next;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_OP;
            r_opcode    <= 8'd0;
            r_esc       <= 1'b0;
            r_modrm     <= 8'd0;
            r_left      <= 3'd0;
            r_disp      <= 32'd0;
            r_imm       <= 32'd0;
            r_gs        <= 1'b0;
            r_len       <= 4'd0;
            r_base      <= 32'd0;
            r_base_next <= 32'd1;
            r_byte_addr <= 32'd0;
            r_next_addr <= 32'd1;
            r_start     <= 32'd0;
        end else if (i_cfg_we) begin
            // new base drops any partial instruction
            r_phase     <= PH_OP;
            r_opcode    <= 8'd0;
            r_esc       <= 1'b0;
            r_modrm     <= 8'd0;
            r_left      <= 3'd0;
            r_disp      <= 32'd0;
            r_imm       <= 32'd0;
            r_gs        <= 1'b0;
            r_len       <= 4'd0;
            r_base      <= i_cfg_wdata;
            r_base_next <= i_cfg_wdata + 32'd1;
            r_byte_addr <= i_cfg_wdata;
            r_next_addr <= i_cfg_wdata + 32'd1;
        end else if (i_fire) begin
            r_phase     <= n_phase;
            r_opcode    <= n_opcode;
            r_esc       <= n_esc;
            r_modrm     <= n_modrm;
            r_left      <= n_left;
            r_disp      <= n_disp;
            r_imm       <= n_imm;
            r_gs        <= n_gs;
            r_len       <= n_len;
            r_byte_addr <= n_byte_addr;
            r_next_addr <= n_next_addr;
            r_start     <= n_start;
        end
    end

    assign o_rec_valid = i_fire && rec_v;
    assign o_rec       = rec;

    a_len_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rec_valid |-> (o_rec.length != 4'd0) && (o_rec.length <= 4'd11))
        else $error("record length out of range");

    a_next_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_next_addr == r_byte_addr + 32'd1)
        else $error("next address tracker out of step");

    a_cfg_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |=> (r_phase == PH_OP) && !r_gs && (r_len == 4'd0))
        else $error("base write did not clear decode state");

    a_left_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_DISP || r_phase == PH_IMM || r_phase == PH_ENDBR)
            |-> (r_left != 3'd0))
        else $error("byte counter empty in a counting phase");

    a_ret_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rec_valid && o_rec.function_end)
            |-> (o_rec.status == ST_OK) && (o_rec.length <= 4'd2))
        else $error("function end on a bad record");

endmodule

@@ hw/rtl/xsid_out_reg.sv @@
// ----------------------------------------------------------------------------
// xsid_out_reg
// Result register; holds one decoded record until the sink takes it.
// ----------------------------------------------------------------------------
module xsid_out_reg
    import xsid_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_rec_valid,
    input  t_record i_rec,
    input  logic    i_m_tready,
    output logic    o_free,
    output logic    o_tvalid,
    output t_record o_rec
);

    logic    r_valid;
    t_record r_rec;

    // register can take a record: empty, or the current one leaves now
    assign o_free = !r_valid || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_rec_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free && i_rec_valid) begin
            r_rec <= i_rec;
        end
    end

    assign o_tvalid = r_valid;
    assign o_rec    = r_rec;

endmodule

@@ hw/rtl/x86_subset_instruction_decoder.sv @@
// ----------------------------------------------------------------------------
// x86_subset_instruction_decoder
// Byte-serial decoder for a subset of 32-bit x86 code with record output.
// ----------------------------------------------------------------------------
// Takes one code byte per clock and emits one record per instruction (or per
// error). Each byte is captured in an input register and held there until the
// result register can take a record; the decode stage then updates the decode
// state and loads the result register, which offers the record of the
// instruction that the byte completes. Throughput is one byte per cycle as long
// as the sink keeps taking records; the single decode stage that carries the
// state from one byte to the next sets that figure. Writing base_address
// restarts the address count and drops any partial instruction; it is meant to
// be written while no byte is in flight. There is no clearing pass after reset.
module x86_subset_instruction_decoder
    import xsid_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    // base_address register
    input  logic         i_cfg_we,
    input  logic [31:0]  i_cfg_wdata,
    // code bytes in
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    input  logic [7:0]   i_s_axis_tdata,   // [7:0] code_byte
    input  logic         i_s_axis_tlast,   // end_of_buffer
    // records out
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // [7:0] opcode, [9:8] mode_bits, [12:10] reg_bits, [15:13] rm_bits,
    // [47:16] displacement, [79:48] immediate, [111:80] branch_target,
    // [143:112] start_address, [147:144] length, [151:148] zero
    output logic [151:0] o_m_axis_tdata,
    output logic [2:0]   o_m_axis_tuser,   // [0] extended, [2:1] status
    output logic         o_m_axis_tlast    // function_end
);

    t_in_item in_item;
    t_in_item held_item;
    logic     held_valid;
    logic     out_free;
    logic     fire;
    logic     rec_valid;
    t_record  rec;
    t_record  out_rec;

    assign in_item.code_byte     = i_s_axis_tdata;
    assign in_item.end_of_buffer = i_s_axis_tlast;

    xsid_in_reg u_in_reg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_axis_tvalid),
        .i_item     (in_item),
        .o_s_tready (o_s_axis_tready),
        .i_take     (out_free),
        .o_valid    (held_valid),
        .o_item     (held_item)
    );

    assign fire = held_valid && out_free;

    xsid_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_fire      (fire),
        .i_item      (held_item),
        .o_rec_valid (rec_valid),
        .o_rec       (rec)
    );

    xsid_out_reg u_out_reg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rec_valid (rec_valid),
        .i_rec       (rec),
        .i_m_tready  (i_m_axis_tready),
        .o_free      (out_free),
        .o_tvalid    (o_m_axis_tvalid),
        .o_rec       (out_rec)
    );

    assign o_m_axis_tdata = {4'd0,
                             out_rec.length,
                             out_rec.start_address,
                             out_rec.branch_target,
                             out_rec.immediate,
                             out_rec.displacement,
                             out_rec.rm_bits,
                             out_rec.reg_bits,
                             out_rec.mode_bits,
                             out_rec.opcode};
    assign o_m_axis_tuser = {out_rec.status, out_rec.extended};
    assign o_m_axis_tlast = out_rec.function_end;

endmodule

@@ test/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the byte-serial x86 subset decoder.
// ----------------------------------------------------------------------------
// Code bytes are streamed in with random gaps while the record sink stalls at
// random. A behavioral decoder tracks every accepted byte and queues the record
// it should produce; each record that leaves the block is compared field by
// field with the oldest queued one. Directed streams hit the special forms
// (endbr32, GS prefix, SIB, group encodings, truncation, address wrap), then
// mostly well-formed random instructions with some noise run under several
// base addresses.
module tb
    import xsid_pkg::*;
();

    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 8;

    localparam logic [7:0] BYTE_UNKNOWN     = 8'h00;

    localparam logic [7:0] KNOWN_OPS [0:31] = '{
        OP_NOP, OP_PUSH_EBP, OP_LEAVE, OP_RET, OP_PUSH_EBX, OP_PUSH_EDX, OP_PUSH_EAX,
        OP_MOV_RM_R, OP_MOV_R_RM, OP_LEA, OP_ADD_RM_R, OP_TEST, OP_CMP_R_RM,
        OP_CMP_RM_R, OP_XOR_RM, OP_GRP5, OP_XOR_GS, OP_GRP1_8, OP_MOV_RM_IMM,
        OP_GRP1_32, OP_CALL, OP_ADD_EAX_IMM, OP_MOV_EAX_IMM, OP_MOV_EAX_MOFFS,
        OP_JMP_SHORT, OP_JLE, OP_JNE, OP_JB, OP_JA, OP_JE, OP_CMP_AL_IMM, OP_PUSH_IMM8
    };

    // ModR/M field codes
    localparam logic [1:0] MOD_MEM    = 2'd0;
    localparam logic [1:0] MOD_DISP8  = 2'd1;
    localparam logic [1:0] MOD_DISP32 = 2'd2;
    localparam logic [1:0] MOD_REG    = 2'd3;
    localparam logic [2:0] RM_SIB     = 3'd4;
    localparam logic [2:0] RM_DISP32  = 3'd5;
    localparam logic [2:0] GRP1_ADD   = 3'd0;
    localparam logic [2:0] GRP1_OR    = 3'd1;
    localparam logic [2:0] GRP1_SUB   = 3'd5;
    localparam logic [2:0] GRP1_CMP   = 3'd7;
    localparam logic [2:0] GRP5_PUSH  = 3'd6;

    typedef enum logic [2:0] {
        DEC_OPCODE, DEC_ESCAPE, DEC_ENDBR, DEC_MODRM, DEC_DISP, DEC_IMM
    } t_dec_phase;

    typedef struct packed {
        logic known;
        logic has_modrm;
        logic imm8;
        logic imm32;
        logic branch;
        logic needs_gs;
    } t_op_traits;

    logic         i_clk;
    logic         i_rst_n;
    logic         i_cfg_we;
    logic [31:0]  i_cfg_wdata;
    logic         i_s_axis_tvalid;
    logic         o_s_axis_tready;
    logic [7:0]   i_s_axis_tdata;
    logic         i_s_axis_tlast;
    logic         o_m_axis_tvalid;
    logic         i_m_axis_tready;
    logic [151:0] o_m_axis_tdata;
    logic [2:0]   o_m_axis_tuser;
    logic         o_m_axis_tlast;

    x86_subset_instruction_decoder i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    // decoder state mirrored by the bench
    t_dec_phase  dec_phase;
    logic [31:0] base_addr;
    logic [31:0] next_addr;
    logic [31:0] instr_addr;
    logic [31:0] disp_acc;
    logic [31:0] imm_acc;
    logic [7:0]  cur_op;
    logic [7:0]  cur_modrm;
    logic        cur_ext;
    logic        gs_seen;
    logic [2:0]  remaining;
    logic [3:0]  instr_len;

    t_record     expected_records[$];
    logic [7:0]  pending[$];
    int          mismatches  = 0;
    int          cycle_count = 0;
    bit          quiet_tail  = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic t_op_traits traits_of(input logic [7:0] op, input logic ext);
        t_op_traits t;
        t = '0;
        if (ext) begin
            t.known     = (op == OP_MOVZX) || (op == OP_TEST);
            t.has_modrm = t.known;
        end else begin
            case (op)
                OP_NOP, OP_PUSH_EBP, OP_LEAVE, OP_RET, OP_PUSH_EBX, OP_PUSH_EDX,
                OP_PUSH_EAX: begin
                    t.known = 1'b1;
                end
                OP_MOV_RM_R, OP_MOV_R_RM, OP_LEA, OP_ADD_RM_R, OP_TEST, OP_CMP_R_RM,
                OP_CMP_RM_R, OP_XOR_RM, OP_GRP5: begin
                    t.known     = 1'b1;
                    t.has_modrm = 1'b1;
                end
                OP_XOR_GS: begin
                    t.known     = 1'b1;
                    t.has_modrm = 1'b1;
                    t.needs_gs  = 1'b1;
                end
                OP_GRP1_8: begin
                    t.known     = 1'b1;
                    t.has_modrm = 1'b1;
                    t.imm8      = 1'b1;
                end
                OP_MOV_RM_IMM, OP_GRP1_32: begin
                    t.known     = 1'b1;
                    t.has_modrm = 1'b1;
                    t.imm32     = 1'b1;
                end
                OP_CALL: begin
                    t.known  = 1'b1;
                    t.imm32  = 1'b1;
                    t.branch = 1'b1;
                end
                OP_ADD_EAX_IMM, OP_MOV_EAX_IMM: begin
                    t.known = 1'b1;
                    t.imm32 = 1'b1;
                end
                OP_MOV_EAX_MOFFS: begin
                    t.known    = 1'b1;
                    t.imm32    = 1'b1;
                    t.needs_gs = 1'b1;
                end
                OP_JMP_SHORT, OP_JLE, OP_JNE, OP_JB, OP_JA, OP_JE: begin
                    t.known  = 1'b1;
                    t.imm8   = 1'b1;
                    t.branch = 1'b1;
                end
                OP_CMP_AL_IMM, OP_PUSH_IMM8: begin
                    t.known = 1'b1;
                    t.imm8  = 1'b1;
                end
                default: begin
                    t = '0;
                end
            endcase
        end
        return t;
    endfunction

    function automatic logic modrm_allowed(input logic [7:0] op, input logic ext,
                                           input logic [7:0] m);
        if (m[7:6] != MOD_REG && m[2:0] == RM_SIB) return 1'b0;
        if (ext) return 1'b1;
        case (op)
            OP_XOR_RM:  return m[7:6] == MOD_REG;
            OP_XOR_GS:  return m[7:6] == MOD_MEM && m[2:0] == RM_DISP32;
            OP_GRP5:    return m[5:3] == GRP5_PUSH;
            OP_GRP1_8:  return m[5:3] == GRP1_ADD || m[5:3] == GRP1_SUB || m[5:3] == GRP1_CMP;
            OP_GRP1_32: return m[5:3] == GRP1_ADD;
            default:    return 1'b1;
        endcase
    endfunction

    function automatic logic [2:0] disp_bytes(input logic [7:0] m);
        if (m[7:6] == MOD_DISP8) return 3'd1;
        if (m[7:6] == MOD_DISP32) return 3'd4;
        if (m[7:6] == MOD_MEM && m[2:0] == RM_DISP32) return 3'd4;
        return 3'd0;
    endfunction

    function automatic logic [2:0] imm_bytes(input t_op_traits t);
        if (t.imm32) return 3'd4;
        if (t.imm8) return 3'd1;
        return 3'd0;
    endfunction

    task automatic clear_decode();
        dec_phase = DEC_OPCODE;
        cur_op    = '0;
        cur_ext   = 1'b0;
        cur_modrm = '0;
        remaining = '0;
        disp_acc  = '0;
        imm_acc   = '0;
        gs_seen   = 1'b0;
        instr_len = '0;
    endtask

    // after ModR/M and displacement: either the immediate follows or we are done
    task automatic after_addressing(output logic done);
        logic [2:0] sz;
        sz   = imm_bytes(traits_of(cur_op, cur_ext));
        done = 1'b0;
        if (sz != 0) begin
            dec_phase = DEC_IMM;
            remaining = sz;
        end else begin
            done = 1'b1;
        end
    endtask

    task automatic open_opcode(output logic done, output logic [1:0] st);
        t_op_traits t;
        t    = traits_of(cur_op, cur_ext);
        done = 1'b0;
        st   = ST_OK;
        if (!t.known) begin
            done = 1'b1;
            st   = ST_UNKNOWN;
        end else if (t.needs_gs && !gs_seen) begin
            done = 1'b1;
            st   = ST_UNSUP;
        end else if (t.has_modrm) begin
            dec_phase = DEC_MODRM;
        end else begin
            after_addressing(done);
        end
    endtask

    task automatic decode_byte(input logic [7:0] b, input logic eob);
        logic        done;
        logic [1:0]  st;
        logic [2:0]  sz;
        logic [1:0]  pos;
        logic [7:0]  want_byte;
        logic        ok;
        t_op_traits  tr;
        t_record     rec;
        if (dec_phase == DEC_OPCODE && !gs_seen) begin
            clear_decode();
            instr_addr = next_addr;
        end
        next_addr = next_addr + 32'd1;
        if (instr_len != 4'hF) instr_len = instr_len + 4'd1;
        done = 1'b0;
        st   = ST_OK;
        case (dec_phase)
            DEC_ESCAPE: begin
                cur_op  = b;
                cur_ext = 1'b1;
                open_opcode(done, st);
            end
            DEC_ENDBR: begin
                case (remaining)
                    3'd3:    want_byte = OP_ESC;
                    3'd2:    want_byte = OP_ENDBR_2;
                    default: want_byte = OP_ENDBR_3;
                endcase
                if (b != want_byte) begin
                    done = 1'b1;
                    st   = ST_UNSUP;
                end else begin
                    remaining = remaining - 3'd1;
                    done      = (remaining == 3'd0);
                end
            end
            DEC_MODRM: begin
                cur_modrm = b;
                sz        = disp_bytes(b);
                if (!modrm_allowed(cur_op, cur_ext, b)) begin
                    done = 1'b1;
                    st   = ST_UNSUP;
                end else if (sz != 0) begin
                    dec_phase = DEC_DISP;
                    remaining = sz;
                end else begin
                    after_addressing(done);
                end
            end
            DEC_DISP: begin
                sz        = disp_bytes(cur_modrm);
                pos       = 2'(sz - remaining);
                disp_acc  = disp_acc | (32'(b) << (8 * pos));
                remaining = remaining - 3'd1;
                if (remaining == 3'd0) begin
                    if (sz == 3'd1) disp_acc = {{24{disp_acc[7]}}, disp_acc[7:0]};
                    after_addressing(done);
                end
            end
            DEC_IMM: begin
                sz        = imm_bytes(traits_of(cur_op, cur_ext));
                pos       = 2'(sz - remaining);
                imm_acc   = imm_acc | (32'(b) << (8 * pos));
                remaining = remaining - 3'd1;
                if (remaining == 3'd0) begin
                    if (sz == 3'd1) imm_acc = {{24{imm_acc[7]}}, imm_acc[7:0]};
                    done = 1'b1;
                end
            end
            default: begin
                if (b == OP_GS) begin
                    // a second prefix is rejected with the prefix as opcode
                    if (gs_seen) begin
                        done = 1'b1;
                        st   = ST_UNSUP;
                    end
                    cur_op  = OP_GS;
                    gs_seen = 1'b1;
                end else begin
                    cur_op = b;
                    if (b == OP_ESC) begin
                        dec_phase = DEC_ESCAPE;
                    end else if (b == OP_REP) begin
                        dec_phase = DEC_ENDBR;
                        remaining = 3'd3;
                    end else begin
                        open_opcode(done, st);
                    end
                end
            end
        endcase

        if (!done && eob) begin
            done = 1'b1;
            st   = ST_TRUNC;
        end
        if (done) begin
            ok                = (st == ST_OK);
            tr                = traits_of(cur_op, cur_ext);
            rec.opcode        = cur_op;
            rec.extended      = cur_ext;
            rec.status        = st;
            rec.mode_bits     = cur_modrm[7:6];
            rec.reg_bits      = cur_modrm[5:3];
            rec.rm_bits       = cur_modrm[2:0];
            rec.displacement  = ok ? disp_acc : '0;
            rec.immediate     = ok ? imm_acc : '0;
            rec.branch_target = (ok && tr.branch) ? next_addr + imm_acc : '0;
            rec.start_address = instr_addr;
            rec.length        = instr_len;
            rec.function_end  = ok && cur_op == OP_RET && !cur_ext;
            expected_records.push_back(rec);
            clear_decode();
            if (eob) next_addr = base_addr;
        end
    endtask

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %h, got %h", $time, name, want, got);
            mismatches++;
        end
    endtask

    // tracks every transfer on both sides and the register write
    always @(posedge i_clk) begin : monitor
        t_record want;
        if (!i_rst_n) begin
            base_addr  = '0;
            next_addr  = '0;
            instr_addr = '0;
            clear_decode();
        end else begin
            if (i_cfg_we) begin
                base_addr = i_cfg_wdata;
                next_addr = i_cfg_wdata;
                clear_decode();
            end
            if (i_s_axis_tvalid && o_s_axis_tready)
                decode_byte(i_s_axis_tdata, i_s_axis_tlast);
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                if (expected_records.size() == 0) begin
                    $display("%0t: record with nothing expected, got opcode %h status %h",
                             $time, o_m_axis_tdata[7:0], o_m_axis_tuser[2:1]);
                    mismatches++;
                end else begin
                    want = expected_records.pop_front();
                    compare_field("opcode", 32'(want.opcode), 32'(o_m_axis_tdata[7:0]));
                    compare_field("extended", 32'(want.extended), 32'(o_m_axis_tuser[0]));
                    compare_field("status", 32'(want.status), 32'(o_m_axis_tuser[2:1]));
                    compare_field("mode_bits", 32'(want.mode_bits),
                                  32'(o_m_axis_tdata[9:8]));
                    compare_field("reg_bits", 32'(want.reg_bits),
                                  32'(o_m_axis_tdata[12:10]));
                    compare_field("rm_bits", 32'(want.rm_bits), 32'(o_m_axis_tdata[15:13]));
                    compare_field("displacement", want.displacement, o_m_axis_tdata[47:16]);
                    compare_field("immediate", want.immediate, o_m_axis_tdata[79:48]);
                    compare_field("branch_target", want.branch_target,
                                  o_m_axis_tdata[111:80]);
                    compare_field("start_address", want.start_address,
                                  o_m_axis_tdata[143:112]);
                    compare_field("length", 32'(want.length), 32'(o_m_axis_tdata[147:144]));
                    compare_field("tdata pad", 32'd0, 32'(o_m_axis_tdata[151:148]));
                    compare_field("function_end", 32'(want.function_end),
                                  32'(o_m_axis_tlast));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // record sink: stall bursts, or always ready in the tail
    initial begin
        i_m_axis_tready = 1'b0;
        @(posedge i_clk);
        forever begin
            if (!quiet_tail && $urandom_range(0, 3) == 0) begin
                i_m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge i_clk);
            end
            i_m_axis_tready <= 1'b1;
            repeat ($urandom_range(1, 40)) @(posedge i_clk);
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic eob);
        if (!quiet_tail && $urandom_range(0, 6) == 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= b;
        i_s_axis_tlast  <= eob;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
    endtask

    task automatic flush_pending(input logic eob);
        int i;
        for (i = 0; i < pending.size(); i++)
            send_byte(pending[i], eob && i == pending.size() - 1);
    endtask

    task automatic drain_and_settle();
        i_s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (expected_records.size() != 0) @(posedge i_clk);
        // bytes that complete nothing may still sit in the pipeline
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic load_base(input logic [31:0] addr);
        drain_and_settle();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= addr;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    function automatic logic [7:0] pick_modrm(input logic [7:0] op, input logic ext);
        logic [1:0] md;
        logic [2:0] rg;
        logic [2:0] rm;
        md = 2'($urandom);
        rg = 3'($urandom);
        rm = 3'($urandom);
        if (md != MOD_REG && rm == RM_SIB) rm = 3'($urandom_range(5, 7));
        if (!ext) begin
            case (op)
                OP_XOR_RM: md = MOD_REG;
                OP_XOR_GS: begin
                    md = MOD_MEM;
                    rm = RM_DISP32;
                end
                OP_GRP5:    rg = GRP5_PUSH;
                OP_GRP1_8: begin
                    case ($urandom_range(0, 2))
                        0:       rg = GRP1_ADD;
                        1:       rg = GRP1_SUB;
                        default: rg = GRP1_CMP;
                    endcase
                end
                OP_GRP1_32: rg = GRP1_ADD;
                default: ;
            endcase
        end
        return {md, rg, rm};
    endfunction

    // one well-formed instruction with random operands into the pending queue
    task automatic build_instruction();
        logic [7:0] op;
        logic       ext;
        logic [7:0] m;
        t_op_traits t;
        pending.delete();
        ext = 1'b0;
        if ($urandom_range(0, 19) == 0) begin
            pending = '{OP_REP, OP_ESC, OP_ENDBR_2, OP_ENDBR_3};
        end else begin
            if ($urandom_range(0, 19) == 0) begin
                op  = $urandom_range(0, 1) ? OP_MOVZX : OP_TEST;
                ext = 1'b1;
            end else begin
                op = KNOWN_OPS[$urandom_range(0, 31)];
            end
            t = traits_of(op, ext);
            if (t.needs_gs || $urandom_range(0, 15) == 0) pending.push_back(OP_GS);
            if (ext) pending.push_back(OP_ESC);
            pending.push_back(op);
            if (t.has_modrm) begin
                m = pick_modrm(op, ext);
                pending.push_back(m);
                repeat (disp_bytes(m)) pending.push_back(8'($urandom));
            end
            repeat (imm_bytes(t)) pending.push_back(8'($urandom));
        end
    endtask

    task automatic run_random_stream(input int n_bytes);
        int   sent;
        int   pick;
        int   cut;
        logic eob;
        sent = 0;
        while (sent < n_bytes) begin
            pick = $urandom_range(0, 99);
            eob  = ($urandom_range(0, 39) == 0);
            if (pick < 8) begin
                pending = '{8'($urandom)};
            end else begin
                build_instruction();
                if (pick < 13 && pending.size() > 1) begin
                    // cut short and end the buffer mid-instruction
                    cut = $urandom_range(1, pending.size() - 1);
                    while (pending.size() > cut) void'(pending.pop_back());
                    eob = 1'b1;
                end else if (pick < 18 && pending.size() > 1) begin
                    pending[$urandom_range(1, pending.size() - 1)] = 8'($urandom);
                end
            end
            flush_pending(eob);
            sent += pending.size();
            if ($urandom_range(0, 149) == 0) drain_and_settle();
        end
    endtask

    task automatic test_simple_and_endbr();
        pending = '{OP_RET};
        flush_pending(1'b0);
        pending = '{OP_REP, OP_ESC, OP_ENDBR_2, OP_ENDBR_3};
        flush_pending(1'b0);
        pending = '{OP_REP, OP_ESC, OP_NOP};
        flush_pending(1'b0);
        pending = '{BYTE_UNKNOWN};
        flush_pending(1'b0);
        pending = '{OP_ESC, OP_NOP};
        flush_pending(1'b0);
    endtask

    task automatic test_prefix_forms();
        pending = '{OP_GS, OP_MOV_EAX_MOFFS, 8'h00, 8'h00, 8'h00, 8'h80};
        flush_pending(1'b0);
        pending = '{OP_MOV_EAX_MOFFS};
        flush_pending(1'b0);
        pending = '{OP_GS, OP_GS};
        flush_pending(1'b0);
        pending = '{OP_GS, OP_XOR_GS, {MOD_MEM, 3'd7, RM_DISP32}, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
        flush_pending(1'b0);
        pending = '{OP_ESC};
        flush_pending(1'b1);
        pending = '{OP_GS};
        flush_pending(1'b1);
    endtask

    task automatic test_modrm_forms();
        pending = '{OP_MOV_RM_R, {MOD_DISP8, 3'd0, RM_SIB}};
        flush_pending(1'b0);
        pending = '{OP_MOV_R_RM, {MOD_DISP8, 3'd0, RM_DISP32}, 8'h80};
        flush_pending(1'b0);
        pending = '{OP_GRP1_32, {MOD_REG, GRP1_ADD, 3'd0}, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
        flush_pending(1'b0);
        pending = '{OP_GRP1_8, {MOD_REG, GRP1_OR, 3'd0}};
        flush_pending(1'b0);
        pending = '{OP_GRP5, {MOD_DISP32, GRP5_PUSH, 3'd3}, 8'hFF, 8'hFF, 8'hFF, 8'h7F};
        flush_pending(1'b0);
        pending = '{OP_ESC, OP_MOVZX, {MOD_MEM, 3'd2, RM_DISP32}, 8'h00, 8'h00, 8'h00, 8'h80};
        flush_pending(1'b0);
        pending = '{OP_XOR_RM, {MOD_MEM, 3'd0, 3'd0}};
        flush_pending(1'b0);
        pending = '{OP_MOV_EAX_IMM, 8'h11, 8'h22};
        flush_pending(1'b1);
    endtask

    // branch targets and addresses wrapping past the top of memory
    task automatic test_branches_at_top();
        load_base(32'hFFFF_FFFA);
        pending = '{OP_CALL, 8'h00, 8'h00, 8'h00, 8'h00, OP_JMP_SHORT, 8'hFE, OP_JE, 8'h80};
        flush_pending(1'b0);
        pending = '{OP_PUSH_IMM8, 8'h7F, OP_RET};
        flush_pending(1'b1);
        pending = '{OP_JNE, 8'h7F};
        flush_pending(1'b0);
        load_base(32'hFFFF_FFFF);
        pending = '{OP_NOP};
        flush_pending(1'b1);
    endtask

    task automatic test_random_streams();
        load_base(32'h0000_0000);
        run_random_stream(300);
        // hold the stream until the sink has caught up
        drain_and_settle();
        run_random_stream(300);
        load_base(32'hFFFF_FFF8);
        run_random_stream(400);
        load_base($urandom);
        run_random_stream(400);
    endtask

    task automatic test_quiet_tail();
        quiet_tail = 1'b1;
        load_base($urandom);
        run_random_stream(400);
    endtask

    initial begin
        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_wdata     = '0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        i_s_axis_tlast  = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_simple_and_endbr();
        test_prefix_forms();
        test_modrm_forms();
        test_branches_at_top();
        test_random_streams();
        test_quiet_tail();
        drain_and_settle();
        if (mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
